// ===== hw/rtl/pff_pkg.sv =====
// shared types, constants and helper functions of the potential field force block
package pff_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;

   // fixed point and datapath widths
   localparam int SUM_W   = 48;
   localparam int FRAC_W  = 16;
   localparam int DIGIT_W = 16;
   localparam int ROOT_W  = 32;
   localparam int RAD_W   = 64;
   localparam int SREM_W  = 34;
   localparam int SUB_W   = 36;
   localparam int DEN_W   = 32;
   localparam int OUT_W   = 32;
   localparam int GAIN_W  = 24;
   localparam int REG_W   = 31;
   localparam int CSR_W   = 3;

   localparam logic [SUM_W-1:0] SUM_CAP  = 48'h7FFF_FFFF_FFFF;
   localparam logic [DEN_W-1:0] MIN_DIST = 32'd66;
   localparam logic [REG_W-1:0] MAG_MAX  = 31'h7FFF_FFFF;

   // request kinds
   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_OBSTACLE = 1'b1;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_ATTRACT_GAIN     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_REPEL_GAIN       = 3'd1;
   localparam logic [CSR_W-1:0] CSR_INFLUENCE_RADIUS = 3'd2;
   localparam logic [CSR_W-1:0] CSR_GOAL_THRESHOLD   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_FORCE_LIMIT      = 3'd4;
   localparam logic [CSR_W-1:0] CSR_QUADRATIC_MODE   = 3'd5;

   // register reset values
   localparam logic [GAIN_W-1:0] ATTRACT_GAIN_RST     = 24'd65536;
   localparam logic [GAIN_W-1:0] REPEL_GAIN_RST       = 24'd655360;
   localparam logic [REG_W-1:0]  INFLUENCE_RADIUS_RST = 31'd131072;
   localparam logic [REG_W-1:0]  GOAL_THRESHOLD_RST   = 31'd32768;
   localparam logic [REG_W-1:0]  FORCE_LIMIT_RST      = 31'd327680;
   localparam logic              QUADRATIC_MODE_RST   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_ROOT,
      S_WRAP
   } state_type;

   typedef enum logic [1:0] {
      JOB_START,
      JOB_OBST,
      JOB_EMIT
   } job_type;

   typedef enum logic [3:0] {
      STEP_SQ_X,
      STEP_SQ_Y,
      STEP_ROOT,
      STEP_OP0,
      STEP_OP1,
      STEP_OP2,
      STEP_OP3,
      STEP_OP4,
      STEP_OP5,
      STEP_OP6,
      STEP_OP7,
      STEP_OP8,
      STEP_OP9
   } step_type;

   // magnitude with the sign of the reference applied
   function automatic logic signed [SUM_W-1:0] apply_sign(input logic [SUM_W-1:0] m,
                                                          input logic neg);
      logic signed [SUM_W-1:0] v;
      v = $signed(m);
      return neg ? -v : v;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32'sh7FFF_FFFF);
      lo = -SUM_W'(33'sh0_8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[OUT_W-1:0];
   endfunction

   // accumulator add, clamped to the symmetric range
   function automatic logic signed [SUM_W-1:0] clamp_add(input logic signed [SUM_W-1:0] a,
                                                         input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      logic signed [SUM_W:0] cap;
      s   = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      cap = $signed({1'b0, SUM_CAP});
      if (s > cap) begin
         return $signed(SUM_CAP);
      end else if (s < -cap) begin
         return -$signed(SUM_CAP);
      end
      return s[SUM_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/potential_field_force.sv =====
// potential field force: attraction toward a goal plus repulsion from streamed obstacles
//
// A query is a start item (robot and goal) followed by obstacle items; the item with
// last set makes the block emit the total force, scaled to force_limit when longer.
// The block takes one item at a time and drops req_ready while it works. All math runs
// through one 16-bit-digit multiplier and one shared subtractor that does the restoring
// divide (one quotient bit per cycle) and the square root. An obstacle inside the radius
// runs four divides. The result sits in an output register, so the next query may start
// while it waits to be taken.
module potential_field_force #(
   parameter int COORD_WIDTH = pff_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [COORD_WIDTH-1:0]     req_pos_a_x,
   input  logic signed [COORD_WIDTH-1:0]     req_pos_a_y,
   input  logic signed [COORD_WIDTH-1:0]     req_goal_x,
   input  logic signed [COORD_WIDTH-1:0]     req_goal_y,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pff_pkg::OUT_W-1:0]  rsp_force_x,
   output logic signed [pff_pkg::OUT_W-1:0]  rsp_force_y,
   output logic [pff_pkg::REG_W-1:0]         rsp_force_mag,
   output logic                              rsp_was_limited,
   input  logic                              csr_we,
   input  logic [pff_pkg::CSR_W-1:0]         csr_index,
   input  logic [pff_pkg::REG_W-1:0]         csr_wdata
);
   import pff_pkg::*;

   localparam int VW      = (COORD_WIDTH + 1 > SUM_W) ? COORD_WIDTH + 1 : SUM_W;
   localparam int DW      = VW + 1;
   localparam int MUL_DIG = (VW + DIGIT_W - 1) / DIGIT_W;
   localparam int PW      = VW + DIGIT_W * MUL_DIG;
   localparam int SH_W    = $clog2(VW - 30);
   localparam int CNT_W   = $clog2(VW);
   localparam int MD_W    = $clog2(MUL_DIG);
   localparam int CW1     = COORD_WIDTH + 1;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   step_type  pc_ff, pc_in;
   logic      last_ff, last_in;

   logic [GAIN_W-1:0] attract_gain_ff, attract_gain_in;
   logic [GAIN_W-1:0] repel_gain_ff, repel_gain_in;
   logic [REG_W-1:0]  radius_ff, radius_in;
   logic [REG_W-1:0]  threshold_ff, threshold_in;
   logic [REG_W-1:0]  limit_ff, limit_in;
   logic              quad_ff, quad_in;

   logic signed [COORD_WIDTH-1:0] robot_x_ff, robot_x_in, robot_y_ff, robot_y_in;
   logic signed [SUM_W-1:0]       sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;

   logic [VW-1:0]     ox_ff, ox_in, oy_ff, oy_in;
   logic [VW-1:0]     vx_ff, vx_in, vy_ff, vy_in;
   logic              sgx_ff, sgx_in, sgy_ff, sgy_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [RAD_W-1:0]  sq_ff, sq_in;

   logic [VW-1:0]     ma_ff, ma_in, mb_ff, mb_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [MD_W-1:0]   mdig_ff, mdig_in;

   logic [VW-1:0]     dq_ff, dq_in;
   logic [DEN_W-1:0]  drem_ff, drem_in, dden_ff, dden_in;

   logic [VW-1:0]     ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in;

   logic signed [OUT_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [REG_W-1:0]        out_mag_ff, out_mag_in;
   logic                    out_lim_ff, out_lim_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic signed [CW1-1:0] dx, dy;
   logic [CW1-1:0]        dx_mag, dy_mag;
   logic [SUM_W-1:0]      sum_x_mag, sum_y_mag;
   logic [DW-1:0]         dist_len;
   logic [DEN_W-1:0]      lenc, dc, rad_c;
   logic [VW-1:0]         num_x, num_y, num_xe, num_ye, num_invd, num_invr;
   logic [PW-1:0]         rnd;
   logic [PW-1:0]         rnd_hi;
   logic [VW-1:0]         sat_q;
   logic [VW+DIGIT_W-1:0] part;
   logic [SUB_W-1:0]      sub_a, sub_b;
   logic [SUB_W:0]        sub_diff;
   logic                  sub_ok;
   logic                  slot_free;

   assign dx = (req_type == REQ_START) ? CW1'(req_goal_x) - CW1'(req_pos_a_x)
                                       : CW1'(robot_x_ff) - CW1'(req_pos_a_x);
   assign dy = (req_type == REQ_START) ? CW1'(req_goal_y) - CW1'(req_pos_a_y)
                                       : CW1'(robot_y_ff) - CW1'(req_pos_a_y);
   assign dx_mag = dx[CW1-1] ? CW1'(-dx) : CW1'(dx);
   assign dy_mag = dy[CW1-1] ? CW1'(-dy) : CW1'(dy);
   assign sum_x_mag = sum_x_ff[SUM_W-1] ? SUM_W'(-sum_x_ff) : SUM_W'(sum_x_ff);
   assign sum_y_mag = sum_y_ff[SUM_W-1] ? SUM_W'(-sum_y_ff) : SUM_W'(sum_y_ff);

   assign dist_len = DW'(root_ff) << sh_ff;
   assign lenc     = (root_ff < MIN_DIST) ? MIN_DIST : root_ff;
   assign dc       = (dist_len < DW'(MIN_DIST)) ? MIN_DIST : dist_len[DEN_W-1:0];
   assign rad_c    = (DEN_W'(radius_ff) < MIN_DIST) ? MIN_DIST : DEN_W'(radius_ff);

   // rounded quotient numerators: value plus half the divisor
   assign num_x    = (VW'(vx_ff) << FRAC_W) + VW'(lenc >> 1);
   assign num_y    = (VW'(vy_ff) << FRAC_W) + VW'(lenc >> 1);
   assign num_xe   = (VW'(vx_ff) << FRAC_W) + VW'(root_ff >> 1);
   assign num_ye   = (VW'(vy_ff) << FRAC_W) + VW'(root_ff >> 1);
   assign num_invd = (VW'(1) << (2 * FRAC_W)) + VW'(dc >> 1);
   assign num_invr = (VW'(1) << (2 * FRAC_W)) + VW'(rad_c >> 1);

   // q16 product rounding with saturation at the accumulator limit
   assign rnd    = prod_ff + PW'(32768);
   assign rnd_hi = rnd >> FRAC_W;
   assign sat_q  = (rnd_hi > PW'(SUM_CAP)) ? VW'(SUM_CAP) : VW'(rnd_hi[SUM_W-1:0]);

   assign part = ma_ff * mb_ff[DIGIT_W-1:0];

   // shared subtractor for divide and square root steps
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         S_DIV: begin
            sub_a = SUB_W'({drem_ff, dq_ff[VW-1]});
            sub_b = SUB_W'(dden_ff);
         end
         S_ROOT: begin
            sub_a = {srem_ff, rad_ff[RAD_W-1 -: 2]};
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ok    = ~sub_diff[SUB_W];
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         job_ff          <= JOB_START;
         pc_ff           <= STEP_SQ_X;
         last_ff         <= 1'b0;
         attract_gain_ff <= ATTRACT_GAIN_RST;
         repel_gain_ff   <= REPEL_GAIN_RST;
         radius_ff       <= INFLUENCE_RADIUS_RST;
         threshold_ff    <= GOAL_THRESHOLD_RST;
         limit_ff        <= FORCE_LIMIT_RST;
         quad_ff         <= QUADRATIC_MODE_RST;
         robot_x_ff      <= '0;
         robot_y_ff      <= '0;
         sum_x_ff        <= '0;
         sum_y_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         job_ff          <= job_in;
         pc_ff           <= pc_in;
         last_ff         <= last_in;
         attract_gain_ff <= attract_gain_in;
         repel_gain_ff   <= repel_gain_in;
         radius_ff       <= radius_in;
         threshold_ff    <= threshold_in;
         limit_ff        <= limit_in;
         quad_ff         <= quad_in;
         robot_x_ff      <= robot_x_in;
         robot_y_ff      <= robot_y_in;
         sum_x_ff        <= sum_x_in;
         sum_y_ff        <= sum_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      sgx_ff     <= sgx_in;
      sgy_ff     <= sgy_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      rad_ff     <= rad_in;
      sq_ff      <= sq_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      prod_ff    <= prod_in;
      mdig_ff    <= mdig_in;
      dq_ff      <= dq_in;
      drem_ff    <= drem_in;
      dden_ff    <= dden_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      tc_ff      <= tc_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_mag_ff <= out_mag_in;
      out_lim_ff <= out_lim_in;
   end

   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      pc_in           = pc_ff;
      last_in         = last_ff;
      attract_gain_in = attract_gain_ff;
      repel_gain_in   = repel_gain_ff;
      radius_in       = radius_ff;
      threshold_in    = threshold_ff;
      limit_in        = limit_ff;
      quad_in         = quad_ff;
      robot_x_in      = robot_x_ff;
      robot_y_in      = robot_y_ff;
      sum_x_in        = sum_x_ff;
      sum_y_in        = sum_y_ff;
      ox_in           = ox_ff;
      oy_in           = oy_ff;
      vx_in           = vx_ff;
      vy_in           = vy_ff;
      sgx_in          = sgx_ff;
      sgy_in          = sgy_ff;
      sh_in           = sh_ff;
      cnt_in          = cnt_ff;
      root_in         = root_ff;
      srem_in         = srem_ff;
      rad_in          = rad_ff;
      sq_in           = sq_ff;
      ma_in           = ma_ff;
      mb_in           = mb_ff;
      prod_in         = prod_ff;
      mdig_in         = mdig_ff;
      dq_in           = dq_ff;
      drem_in         = drem_ff;
      dden_in         = dden_ff;
      ta_in           = ta_ff;
      tb_in           = tb_ff;
      tc_in           = tc_ff;
      out_x_in        = out_x_ff;
      out_y_in        = out_y_ff;
      out_mag_in      = out_mag_ff;
      out_lim_in      = out_lim_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;

      if (csr_we) begin
         case (csr_index)
            CSR_ATTRACT_GAIN:     attract_gain_in = csr_wdata[GAIN_W-1:0];
            CSR_REPEL_GAIN:       repel_gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_INFLUENCE_RADIUS: radius_in       = csr_wdata;
            CSR_GOAL_THRESHOLD:   threshold_in    = csr_wdata;
            CSR_FORCE_LIMIT:      limit_in        = csr_wdata;
            CSR_QUADRATIC_MODE:   quad_in         = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               ox_in   = VW'(dx_mag);
               oy_in   = VW'(dy_mag);
               vx_in   = VW'(dx_mag);
               vy_in   = VW'(dy_mag);
               sgx_in  = dx[CW1-1];
               sgy_in  = dy[CW1-1];
               sh_in   = '0;
               state_in = S_NORM;
               if (req_type == REQ_START) begin
                  job_in     = JOB_START;
                  robot_x_in = req_pos_a_x;
                  robot_y_in = req_pos_a_y;
               end else begin
                  job_in = JOB_OBST;
               end
            end
         end

         // bring both components below 2^31 one bit a cycle
         S_NORM: begin
            if (|((vx_ff | vy_ff) >> 31)) begin
               vx_in = vx_ff >> 1;
               vy_in = vy_ff >> 1;
               sh_in = sh_ff + SH_W'(1);
            end else begin
               state_in = S_EXEC;
               pc_in    = STEP_SQ_X;
            end
         end

         S_MUL: begin
            prod_in = prod_ff + (PW'(part) << (DIGIT_W * mdig_ff));
            mb_in   = mb_ff >> DIGIT_W;
            mdig_in = mdig_ff + MD_W'(1);
            if (mdig_ff == MD_W'(MUL_DIG - 1)) begin
               state_in = S_EXEC;
            end
         end

         S_DIV: begin
            drem_in = sub_ok ? sub_diff[DEN_W-1:0] : sub_a[DEN_W-1:0];
            dq_in   = {dq_ff[VW-2:0], sub_ok};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VW - 1)) begin
               state_in = S_EXEC;
            end
         end

         S_ROOT: begin
            srem_in = sub_ok ? sub_diff[SREM_W-1:0] : sub_a[SREM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], sub_ok};
            rad_in  = rad_ff << 2;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = S_EXEC;
            end
         end

         S_WRAP: begin
            if (last_ff && job_ff != JOB_EMIT) begin
               job_in   = JOB_EMIT;
               ox_in    = VW'(sum_x_mag);
               oy_in    = VW'(sum_y_mag);
               vx_in    = VW'(sum_x_mag);
               vy_in    = VW'(sum_y_mag);
               sgx_in   = sum_x_ff[SUM_W-1];
               sgy_in   = sum_y_ff[SUM_W-1];
               sh_in    = '0;
               state_in = S_NORM;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_EXEC: begin
            // each step collects the last unit result and launches the next operation or finishes the item
            case (pc_ff)
               STEP_SQ_X: begin
                  ma_in = vx_ff; mb_in = vx_ff; prod_in = '0; mdig_in = '0;
                  state_in = S_MUL; pc_in = STEP_SQ_Y;
               end
               STEP_SQ_Y: begin
                  sq_in = prod_ff[RAD_W-1:0];
                  ma_in = vy_ff; mb_in = vy_ff; prod_in = '0; mdig_in = '0;
                  state_in = S_MUL; pc_in = STEP_ROOT;
               end
               STEP_ROOT: begin
                  rad_in  = sq_ff + prod_ff[RAD_W-1:0];
                  srem_in = '0; root_in = '0; cnt_in = '0;
                  state_in = S_ROOT; pc_in = STEP_OP0;
               end
               default: begin
                  case (job_ff)
                     JOB_START: begin
                        case (pc_ff)
                           STEP_OP0: begin
                              if (dist_len < DW'(threshold_ff)) begin
                                 sum_x_in = '0; sum_y_in = '0; state_in = S_WRAP;
                              end else if (quad_ff) begin
                                 ma_in = VW'(attract_gain_ff); mb_in = ox_ff;
                                 prod_in = '0; mdig_in = '0;
                                 state_in = S_MUL; pc_in = STEP_OP1;
                              end else begin
                                 dq_in = num_x; dden_in = lenc; drem_in = '0; cnt_in = '0;
                                 state_in = S_DIV; pc_in = STEP_OP1;
                              end
                           end
                           STEP_OP1: begin
                              if (quad_ff) begin
                                 ta_in = sat_q;
                                 ma_in = VW'(attract_gain_ff); mb_in = oy_ff;
                                 prod_in = '0; mdig_in = '0;
                                 state_in = S_MUL;
                              end else begin
                                 ta_in = dq_ff;
                                 dq_in = num_y; dden_in = lenc; drem_in = '0; cnt_in = '0;
                                 state_in = S_DIV;
                              end
                              pc_in = STEP_OP2;
                           end
                           STEP_OP2: begin
                              if (quad_ff) begin
                                 sum_x_in = apply_sign(ta_ff[SUM_W-1:0], sgx_ff);
                                 sum_y_in = apply_sign(sat_q[SUM_W-1:0], sgy_ff);
                                 state_in = S_WRAP;
                              end else begin
                                 tb_in = dq_ff;
                                 ma_in = VW'(attract_gain_ff); mb_in = ta_ff;
                                 prod_in = '0; mdig_in = '0;
                                 state_in = S_MUL; pc_in = STEP_OP3;
                              end
                           end
                           STEP_OP3: begin
                              ta_in = sat_q;
                              ma_in = VW'(attract_gain_ff); mb_in = tb_ff;
                              prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP4;
                           end
                           default: begin
                              sum_x_in = apply_sign(ta_ff[SUM_W-1:0], sgx_ff);
                              sum_y_in = apply_sign(sat_q[SUM_W-1:0], sgy_ff);
                              state_in = S_WRAP;
                           end
                        endcase
                     end

                     JOB_OBST: begin
                        case (pc_ff)
                           STEP_OP0: begin
                              if (dist_len > DW'(rad_c)) begin
                                 state_in = S_WRAP;
                              end else begin
                                 dq_in = num_invd; dden_in = dc; drem_in = '0; cnt_in = '0;
                                 state_in = S_DIV; pc_in = STEP_OP1;
                              end
                           end
                           STEP_OP1: begin
                              ta_in = dq_ff;
                              dq_in = num_invr; dden_in = rad_c; drem_in = '0; cnt_in = '0;
                              state_in = S_DIV; pc_in = STEP_OP2;
                           end
                           STEP_OP2: begin
                              tb_in = (ta_ff > dq_ff) ? ta_ff - dq_ff : '0;
                              ma_in = ta_ff; mb_in = ta_ff; prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP3;
                           end
                           STEP_OP3: begin
                              tc_in = sat_q;
                              ma_in = VW'(repel_gain_ff); mb_in = tb_ff;
                              prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP4;
                           end
                           STEP_OP4: begin
                              ma_in = sat_q; mb_in = tc_ff; prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP5;
                           end
                           STEP_OP5: begin
                              ta_in = sat_q;
                              dq_in = num_x; dden_in = lenc; drem_in = '0; cnt_in = '0;
                              state_in = S_DIV; pc_in = STEP_OP6;
                           end
                           STEP_OP6: begin
                              tb_in = dq_ff;
                              dq_in = num_y; dden_in = lenc; drem_in = '0; cnt_in = '0;
                              state_in = S_DIV; pc_in = STEP_OP7;
                           end
                           STEP_OP7: begin
                              tc_in = dq_ff;
                              ma_in = ta_ff; mb_in = tb_ff; prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP8;
                           end
                           STEP_OP8: begin
                              tb_in = sat_q;
                              ma_in = ta_ff; mb_in = tc_ff; prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP9;
                           end
                           default: begin
                              sum_x_in = clamp_add(sum_x_ff,
                                                   apply_sign(tb_ff[SUM_W-1:0], sgx_ff));
                              sum_y_in = clamp_add(sum_y_ff,
                                                   apply_sign(sat_q[SUM_W-1:0], sgy_ff));
                              state_in = S_WRAP;
                           end
                        endcase
                     end

                     default: begin
                        case (pc_ff)
                           STEP_OP0: begin
                              if (dist_len > DW'(limit_ff)) begin
                                 dq_in = num_xe; dden_in = root_ff; drem_in = '0; cnt_in = '0;
                                 state_in = S_DIV; pc_in = STEP_OP1;
                              end else if (slot_free) begin
                                 out_x_in     = sat32(sum_x_ff);
                                 out_y_in     = sat32(sum_y_ff);
                                 out_mag_in   = (dist_len > DW'(MAG_MAX)) ? MAG_MAX
                                                                          : dist_len[REG_W-1:0];
                                 out_lim_in   = 1'b0;
                                 rsp_valid_in = 1'b1;
                                 sum_x_in     = '0;
                                 sum_y_in     = '0;
                                 state_in     = S_IDLE;
                              end
                           end
                           STEP_OP1: begin
                              ta_in = dq_ff;
                              dq_in = num_ye; dden_in = root_ff; drem_in = '0; cnt_in = '0;
                              state_in = S_DIV; pc_in = STEP_OP2;
                           end
                           STEP_OP2: begin
                              tb_in = dq_ff;
                              ma_in = ta_ff; mb_in = VW'(limit_ff); prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP3;
                           end
                           STEP_OP3: begin
                              ta_in = sat_q;
                              ma_in = tb_ff; mb_in = VW'(limit_ff); prod_in = '0; mdig_in = '0;
                              state_in = S_MUL; pc_in = STEP_OP4;
                           end
                           default: begin
                              if (slot_free) begin
                                 out_x_in     = sat32(apply_sign(ta_ff[SUM_W-1:0], sgx_ff));
                                 out_y_in     = sat32(apply_sign(sat_q[SUM_W-1:0], sgy_ff));
                                 out_mag_in   = limit_ff;
                                 out_lim_in   = 1'b1;
                                 rsp_valid_in = 1'b1;
                                 sum_x_in     = '0;
                                 sum_y_in     = '0;
                                 state_in     = S_IDLE;
                              end
                           end
                        endcase
                     end
                  endcase
               end
            endcase
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_force_x     = out_x_ff;
   assign rsp_force_y     = out_y_ff;
   assign rsp_force_mag   = out_mag_ff;
   assign rsp_was_limited = out_lim_ff;

`ifndef NO_ASSERTIONS
   // operands of the squaring steps are already normalized
   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && pc_ff == STEP_SQ_X) |-> ((vx_ff | vy_ff) >> 31) == '0)
      else $error("vector not normalized before squaring");

   // every divide has a nonzero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dden_ff != '0))
      else $error("divide by zero");

   // a freshly posted item leaves the accumulators cleared
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (sum_x_ff == '0 && sum_y_ff == '0))
      else $error("accumulators not cleared on emission");

   // accumulators stay inside the symmetric clamp range
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (sum_x_ff != -$signed(SUM_CAP) - 48'sd1) && (sum_y_ff != -$signed(SUM_CAP) - 48'sd1))
      else $error("accumulator outside clamp range");
`endif

endmodule
